// ===== hw/rtl/tlr_pkg.sv =====
// ----------------------------------------------------------------------------
// Thick line rasterizer package
// Shared constants and the command and status types between controller and
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tlr_pkg;

	localparam int TLR_COORD_BITS     = 12;
	localparam int TLR_MAX_LINE_WIDTH = 7;
	localparam int TLR_WIDTH_BITS     = 3;
	localparam int TLR_COLOR_BITS     = 8;

	localparam logic TLR_MODE_LOAD = 1'b0;
	localparam logic TLR_MODE_STEP = 1'b1;

	typedef struct packed {
		logic load;
		logic prep;
		logic start;
		logic emit;
		logic advance;
	} tlr_cmd_t;

	typedef struct packed {
		logic active;
		logic slot_free;
		logic run_last;
	} tlr_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tlr_seg_if.sv =====
// ----------------------------------------------------------------------------
// Line command channel
// Carries load and step words toward the rasterizer with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlr_seg_if
	import tlr_pkg::*;
#(
	parameter int COORD_BITS = TLR_COORD_BITS
);
	logic                              valid;
	logic                              ready;
	logic                              mode;
	logic signed [COORD_BITS-1:0]      x_begin;
	logic signed [COORD_BITS-1:0]      y_begin;
	logic signed [COORD_BITS-1:0]      x_finish;
	logic signed [COORD_BITS-1:0]      y_finish;
	logic [TLR_COLOR_BITS-1:0]         red_in;
	logic [TLR_COLOR_BITS-1:0]         green_in;
	logic [TLR_COLOR_BITS-1:0]         blue_in;
	logic [TLR_WIDTH_BITS-1:0]         brush_width;

	modport source (
		output valid, mode, x_begin, y_begin, x_finish, y_finish,
		output red_in, green_in, blue_in, brush_width,
		input  ready
	);

	modport sink (
		input  valid, mode, x_begin, y_begin, x_finish, y_finish,
		input  red_in, green_in, blue_in, brush_width,
		output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/tlr_pix_if.sv =====
// ----------------------------------------------------------------------------
// Pixel channel
// Carries one pixel word per handshake from the rasterizer to the writer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlr_pix_if
	import tlr_pkg::*;
#(
	parameter int COORD_BITS = TLR_COORD_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_BITS:0]    pixel_x;
	logic signed [COORD_BITS:0]    pixel_y;
	logic [TLR_COLOR_BITS-1:0]     red_out;
	logic [TLR_COLOR_BITS-1:0]     green_out;
	logic [TLR_COLOR_BITS-1:0]     blue_out;
	logic                          last_of_run;
	logic                          line_done;

	modport source (
		output valid, pixel_x, pixel_y, red_out, green_out, blue_out,
		output last_of_run, line_done,
		input  ready
	);

	modport sink (
		input  valid, pixel_x, pixel_y, red_out, green_out, blue_out,
		input  last_of_run, line_done,
		output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/tlr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Thick line rasterizer controller
// Sequences line loads, pixel runs and the Bresenham advance.
// ----------------------------------------------------------------------------
`default_nettype none

module tlr_ctrl
	import tlr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_mode,
	output logic             in_ready,
	input  wire tlr_status_t status,
	output tlr_cmd_t         cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_PREP = 4'b0010,
		S_EMIT = 4'b0100,
		S_ADV  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_mode == TLR_MODE_LOAD) begin
						cmd.load = 1'b1;
						state_d  = S_PREP;
					end else if (status.active) begin
						cmd.start = 1'b1;
						state_d   = S_EMIT;
					end
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_IDLE;
			end
			S_EMIT: begin
				if (status.slot_free) begin
					cmd.emit = 1'b1;
					if (status.run_last) begin
						state_d = S_ADV;
					end
				end
			end
			S_ADV: begin
				cmd.advance = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tlr_datapath.sv =====
// ----------------------------------------------------------------------------
// Thick line rasterizer datapath
// Holds the line state, the brush counters, the error term and the pixel
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tlr_datapath
	import tlr_pkg::*;
#(
	parameter int COORD_BITS     = TLR_COORD_BITS,
	parameter int MAX_LINE_WIDTH = TLR_MAX_LINE_WIDTH
)(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tlr_cmd_t                      cmd,
	output tlr_status_t                        status,
	input  wire logic signed [COORD_BITS-1:0]  x_begin,
	input  wire logic signed [COORD_BITS-1:0]  y_begin,
	input  wire logic signed [COORD_BITS-1:0]  x_finish,
	input  wire logic signed [COORD_BITS-1:0]  y_finish,
	input  wire logic [TLR_COLOR_BITS-1:0]     red_in,
	input  wire logic [TLR_COLOR_BITS-1:0]     green_in,
	input  wire logic [TLR_COLOR_BITS-1:0]     blue_in,
	input  wire logic [TLR_WIDTH_BITS-1:0]     brush_width,
	tlr_pix_if.source                          pixel
);

	localparam int MAX_HALF  = MAX_LINE_WIDTH / 2;
	localparam int HALF_BITS = (MAX_HALF < 1) ? 1 : $clog2(MAX_HALF + 1);
	localparam int CNT_BITS  = HALF_BITS + 1;
	localparam int PIX_BITS  = COORD_BITS + 1;
	localparam int ERR_BITS  = COORD_BITS + 2;

	logic [COORD_BITS-1:0]      cur_x_q, cur_y_q, goal_x_q, goal_y_q;
	logic signed [COORD_BITS:0] diff_x_q, diff_y_q;
	logic [COORD_BITS-1:0]      delta_x_q, delta_y_q;
	logic                       neg_x_q, neg_y_q;
	logic signed [ERR_BITS-1:0] err_q;
	logic [TLR_COLOR_BITS-1:0]  red_q, green_q, blue_q;
	logic [HALF_BITS-1:0]       half_q;
	logic                       active_q;
	logic signed [CNT_BITS-1:0] i_q, j_q;
	logic                       first_q;
	logic                       out_valid_q;

	logic [TLR_WIDTH_BITS-1:0]  width_sat;
	logic [COORD_BITS:0]        abs_x, abs_y;
	logic signed [CNT_BITS-1:0] h_pos, h_neg, h_top;
	logic                       done;
	logic                       run_last;
	logic signed [PIX_BITS-1:0] base_x, base_y, off_x, off_y;
	logic signed [ERR_BITS-1:0] dx_ext, dy_ext, err_next;
	logic                       step_x, step_y;

	assign width_sat = (brush_width > TLR_WIDTH_BITS'(MAX_LINE_WIDTH)) ?
		TLR_WIDTH_BITS'(MAX_LINE_WIDTH) : brush_width;

	assign abs_x = diff_x_q[COORD_BITS] ? -diff_x_q : diff_x_q;
	assign abs_y = diff_y_q[COORD_BITS] ? -diff_y_q : diff_y_q;

	assign h_pos = $signed({1'b0, half_q});
	assign h_neg = -h_pos;
	assign h_top = h_pos - CNT_BITS'(1);

	assign done     = (cur_x_q == goal_x_q) && (cur_y_q == goal_y_q);
	assign run_last = (half_q == '0) || (!first_q && (i_q == h_top) && (j_q == h_top));

	assign base_x = $signed({cur_x_q[COORD_BITS-1], cur_x_q});
	assign base_y = $signed({cur_y_q[COORD_BITS-1], cur_y_q});
	assign off_x  = $signed({{(PIX_BITS-CNT_BITS){i_q[CNT_BITS-1]}}, i_q});
	assign off_y  = $signed({{(PIX_BITS-CNT_BITS){j_q[CNT_BITS-1]}}, j_q});

	assign dx_ext   = $signed({2'b00, delta_x_q});
	assign dy_ext   = $signed({2'b00, delta_y_q});
	assign step_x   = err_q > -dx_ext;
	assign step_y   = err_q < dy_ext;
	assign err_next = err_q - (step_x ? dy_ext : '0) + (step_y ? dx_ext : '0);

	assign status.active    = active_q;
	assign status.slot_free = !out_valid_q || pixel.ready;
	assign status.run_last  = run_last;

	assign pixel.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.prep) begin
				active_q <= 1'b1;
			end else if (cmd.advance && done) begin
				active_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (pixel.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_x_q  <= x_begin;
			cur_y_q  <= y_begin;
			goal_x_q <= x_finish;
			goal_y_q <= y_finish;
			diff_x_q <= $signed({x_finish[COORD_BITS-1], x_finish})
				- $signed({x_begin[COORD_BITS-1], x_begin});
			diff_y_q <= $signed({y_finish[COORD_BITS-1], y_finish})
				- $signed({y_begin[COORD_BITS-1], y_begin});
			neg_x_q  <= !(x_begin < x_finish);
			neg_y_q  <= !(y_begin < y_finish);
			red_q    <= red_in;
			green_q  <= green_in;
			blue_q   <= blue_in;
			half_q   <= HALF_BITS'(width_sat >> 1);
		end
		if (cmd.prep) begin
			delta_x_q <= abs_x[COORD_BITS-1:0];
			delta_y_q <= abs_y[COORD_BITS-1:0];
			if (abs_x[COORD_BITS-1:0] > abs_y[COORD_BITS-1:0]) begin
				err_q <= $signed({3'b000, abs_x[COORD_BITS-1:1]});
			end else begin
				err_q <= -$signed({3'b000, abs_y[COORD_BITS-1:1]});
			end
		end
		if (cmd.start) begin
			i_q     <= h_neg;
			j_q     <= h_neg;
			first_q <= 1'b1;
		end
		if (cmd.emit) begin
			if (first_q) begin
				first_q <= 1'b0;
			end else if (j_q == h_top) begin
				j_q <= h_neg;
				i_q <= i_q + CNT_BITS'(1);
			end else begin
				j_q <= j_q + CNT_BITS'(1);
			end
			pixel.pixel_x     <= first_q ? base_x : base_x + off_x;
			pixel.pixel_y     <= first_q ? base_y : base_y + off_y;
			pixel.red_out     <= red_q;
			pixel.green_out   <= green_q;
			pixel.blue_out    <= blue_q;
			pixel.last_of_run <= run_last;
			pixel.line_done   <= done;
		end
		if (cmd.advance && !done) begin
			err_q <= err_next;
			if (step_x) begin
				cur_x_q <= cur_x_q + (neg_x_q ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
			end
			if (step_y) begin
				cur_y_q <= cur_y_q + (neg_y_q ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/thick_line_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// Thick line rasterizer
// Bresenham line generator that paints a square brush around every point.
//
// The segment channel takes load words (mode 0) and step words (mode 1).
// A load word latches both endpoints, the color and the brush width; the
// block then forms the deltas and the error term in the next cycle, before
// it takes the next word.
// A step word emits the current point followed by 4*h*h brush pixels, with
// h the brush width halved, one pixel word per cycle on the pixel channel
// while the receiver does not stall, and then updates the error term.
// The pixel run is set by the single pixel output register, which is written
// at most once per cycle.
// The last pixel of a run carries last_of_run; every pixel of the run at the
// final endpoint carries line_done, after which the block is idle and step
// words are taken and dropped. A load word always restarts a new line.
// A stalled receiver holds the output register and pauses the run; the next
// segment word is taken while the final pixel still waits.
// Reset leaves the block idle with no line loaded and no pixel pending.
// ----------------------------------------------------------------------------
`default_nettype none

module thick_line_rasterizer_unit
	import tlr_pkg::*;
#(
	parameter int COORD_BITS     = TLR_COORD_BITS,
	parameter int MAX_LINE_WIDTH = TLR_MAX_LINE_WIDTH
)(
	input  wire logic  clk,
	input  wire logic  arst_n,
	tlr_seg_if.sink    segment,
	tlr_pix_if.source  pixel
);

	tlr_cmd_t    cmd;
	tlr_status_t status;

	tlr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (segment.valid),
		.in_mode  (segment.mode),
		.in_ready (segment.ready),
		.status   (status),
		.cmd      (cmd)
	);

	tlr_datapath #(
		.COORD_BITS     (COORD_BITS),
		.MAX_LINE_WIDTH (MAX_LINE_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.x_begin     (segment.x_begin),
		.y_begin     (segment.y_begin),
		.x_finish    (segment.x_finish),
		.y_finish    (segment.y_finish),
		.red_in      (segment.red_in),
		.green_in    (segment.green_in),
		.blue_in     (segment.blue_in),
		.brush_width (segment.brush_width),
		.pixel       (pixel)
	);

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thick line rasterizer testbench
// Sends load and step words to the rasterizer and predicts every pixel word
// of the Bresenham walk with its square brush. The pixel stream is checked in
// order, field by field, while both channels may idle in random bursts.
// ----------------------------------------------------------------------------

module testbench;
	import tlr_pkg::*;

	localparam int CB            = TLR_COORD_BITS;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 80;
	localparam int RANDOM_ITEMS  = 66;
	localparam int CHUNK_ITEMS   = 22;
	localparam int CALM_ITEMS    = 20;

	typedef struct {
		logic                          mode;
		logic signed [CB-1:0]          x_begin;
		logic signed [CB-1:0]          y_begin;
		logic signed [CB-1:0]          x_finish;
		logic signed [CB-1:0]          y_finish;
		logic [TLR_COLOR_BITS-1:0]     red;
		logic [TLR_COLOR_BITS-1:0]     green;
		logic [TLR_COLOR_BITS-1:0]     blue;
		logic [TLR_WIDTH_BITS-1:0]     width;
	} seg_word_t;

	typedef struct {
		logic signed [CB:0]            x;
		logic signed [CB:0]            y;
		logic [TLR_COLOR_BITS-1:0]     red;
		logic [TLR_COLOR_BITS-1:0]     green;
		logic [TLR_COLOR_BITS-1:0]     blue;
		logic                          last;
		logic                          done;
	} pixel_word_t;

	logic clk;
	logic arst_n;

	tlr_seg_if seg_bus ();
	tlr_pix_if pix_bus ();

	thick_line_rasterizer_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.segment (seg_bus),
		.pixel   (pix_bus)
	);

	seg_word_t   word_q[$];
	pixel_word_t pixel_expect_q[$];

	int   words_offered    = 0;
	int   words_taken      = 0;
	int   loads_taken      = 0;
	int   steps_taken      = 0;
	int   idle_steps_taken = 0;
	int   pixels_checked   = 0;
	int   mismatch_count   = 0;
	int   cycle_count      = 0;
	int   send_gap         = 0;
	int   stall_left       = 0;
	logic idle_send        = 1'b1;
	logic idle_recv        = 1'b1;

	// Line walker state; drawing starts clear, as the block's active flag does after reset.
	logic signed [CB-1:0]  pen_x      = '0;
	logic signed [CB-1:0]  pen_y      = '0;
	logic signed [CB-1:0]  end_x      = '0;
	logic signed [CB-1:0]  end_y      = '0;
	logic [CB-1:0]         span_x     = '0;
	logic [CB-1:0]         span_y     = '0;
	logic [1:0]            step_dir   = '0;
	logic signed [CB+1:0]  bres_err   = '0;
	logic [23:0]           ink        = '0;
	logic [1:0]            brush_half = '0;
	logic                  drawing    = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic pixel_word_t brush_pixel(int x, int y, logic last, logic done);
		pixel_word_t p;
		p.x     = x[CB:0];
		p.y     = y[CB:0];
		p.red   = ink[23:16];
		p.green = ink[15:8];
		p.blue  = ink[7:0];
		p.last  = last;
		p.done  = done;
		return p;
	endfunction

	task automatic rasterize_word(seg_word_t w);
		int   xb, yb, xf, yf, dx, dy, wv, h, total, k, e2, err, nx, ny, i, j;
		logic done;
		if (w.mode == TLR_MODE_LOAD) begin
			xb = w.x_begin;
			yb = w.y_begin;
			xf = w.x_finish;
			yf = w.y_finish;
			dx = (xf > xb) ? xf - xb : xb - xf;
			dy = (yf > yb) ? yf - yb : yb - yf;
			wv = w.width;
			if (wv > TLR_MAX_LINE_WIDTH)
				wv = TLR_MAX_LINE_WIDTH;
			h          = wv / 2;
			err        = (dx > dy) ? dx / 2 : -(dy / 2);
			pen_x      = w.x_begin;
			pen_y      = w.y_begin;
			end_x      = w.x_finish;
			end_y      = w.y_finish;
			span_x     = dx[CB-1:0];
			span_y     = dy[CB-1:0];
			step_dir   = {yb >= yf, xb >= xf};
			bres_err   = err[CB+1:0];
			ink        = {w.red, w.green, w.blue};
			brush_half = h[1:0];
			drawing    = 1'b1;
		end else if (drawing) begin
			done  = (pen_x == end_x) && (pen_y == end_y);
			h     = brush_half;
			total = 1 + 4 * h * h;
			pixel_expect_q.insert(pixel_expect_q.size(),
				brush_pixel(pen_x, pen_y, total == 1, done));
			k = 1;
			for (i = -h; i < h; i++) begin
				for (j = -h; j < h; j++) begin
					pixel_expect_q.insert(pixel_expect_q.size(),
						brush_pixel(pen_x + i, pen_y + j, k == total - 1, done));
					k++;
				end
			end
			if (done) begin
				drawing = 1'b0;
			end else begin
				e2  = bres_err;
				err = e2;
				dx  = span_x;
				dy  = span_y;
				nx  = pen_x;
				ny  = pen_y;
				if (e2 > -dx) begin
					err -= dy;
					nx += step_dir[0] ? -1 : 1;
				end
				if (e2 < dy) begin
					err += dx;
					ny += step_dir[1] ? -1 : 1;
				end
				pen_x    = nx[CB-1:0];
				pen_y    = ny[CB-1:0];
				bres_err = err[CB+1:0];
			end
		end
	endtask

	task automatic check_field(string what, logic signed [CB+1:0] want,
			logic signed [CB+1:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("Mismatch on pixel word %0d, %s: expected %0d, got %0d",
					pixels_checked, what, want, got);
		end
	endtask

	// Segment words are taken here and fed to the line walker.
	always @(posedge clk) begin : segment_taker
		seg_word_t w;
		if (arst_n && seg_bus.valid && seg_bus.ready) begin
			w = word_q.pop_front();
			if (w.mode == TLR_MODE_LOAD)
				loads_taken++;
			else if (drawing)
				steps_taken++;
			else
				idle_steps_taken++;
			rasterize_word(w);
			words_taken++;
		end
	end

	always @(negedge clk) begin : segment_driver
		if (arst_n && (!seg_bus.valid || words_offered == words_taken)) begin
			if (send_gap > 0) begin
				seg_bus.valid <= 1'b0;
				send_gap      <= send_gap - 1;
			end else if (word_q.size() != 0 && idle_send && $urandom_range(0, 4) == 0) begin
				seg_bus.valid <= 1'b0;
				send_gap      <= $urandom_range(0, 13);
			end else if (word_q.size() != 0) begin
				seg_bus.valid       <= 1'b1;
				seg_bus.mode        <= word_q[0].mode;
				seg_bus.x_begin     <= word_q[0].x_begin;
				seg_bus.y_begin     <= word_q[0].y_begin;
				seg_bus.x_finish    <= word_q[0].x_finish;
				seg_bus.y_finish    <= word_q[0].y_finish;
				seg_bus.red_in      <= word_q[0].red;
				seg_bus.green_in    <= word_q[0].green;
				seg_bus.blue_in     <= word_q[0].blue;
				seg_bus.brush_width <= word_q[0].width;
				words_offered       <= words_offered + 1;
			end else begin
				seg_bus.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : pixel_sink
		if (arst_n) begin
			if (stall_left > 0) begin
				pix_bus.ready <= 1'b0;
				stall_left    <= stall_left - 1;
			end else if (idle_recv && $urandom_range(0, 5) == 0) begin
				pix_bus.ready <= 1'b0;
				stall_left    <= $urandom_range(0, 13);
			end else begin
				pix_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : pixel_monitor
		pixel_word_t want;
		if (arst_n && pix_bus.valid && pix_bus.ready) begin
			if (pixel_expect_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Unexpected pixel word at (%0d, %0d)",
						pix_bus.pixel_x, pix_bus.pixel_y);
			end else begin
				want = pixel_expect_q.pop_front();
				check_field("pixel_x", want.x, pix_bus.pixel_x);
				check_field("pixel_y", want.y, pix_bus.pixel_y);
				check_field("red_out", want.red, pix_bus.red_out);
				check_field("green_out", want.green, pix_bus.green_out);
				check_field("blue_out", want.blue, pix_bus.blue_out);
				check_field("last_of_run", want.last, pix_bus.last_of_run);
				check_field("line_done", want.done, pix_bus.line_done);
			end
			pixels_checked++;
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out with %0d words unsent and %0d pixel words outstanding",
			word_q.size(), pixel_expect_q.size());
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic push_step();
		seg_word_t w;
		w.mode     = TLR_MODE_STEP;
		w.x_begin  = $urandom;
		w.y_begin  = $urandom;
		w.x_finish = $urandom;
		w.y_finish = $urandom;
		w.red      = $urandom;
		w.green    = $urandom;
		w.blue     = $urandom;
		w.width    = $urandom;
		word_q.insert(word_q.size(), w);
	endtask

	task automatic push_line(int xb, int yb, int xf, int yf, logic [23:0] colour,
			logic [TLR_WIDTH_BITS-1:0] width, int steps);
		seg_word_t w;
		w.mode     = TLR_MODE_LOAD;
		w.x_begin  = xb[CB-1:0];
		w.y_begin  = yb[CB-1:0];
		w.x_finish = xf[CB-1:0];
		w.y_finish = yf[CB-1:0];
		w.red      = colour[23:16];
		w.green    = colour[15:8];
		w.blue     = colour[7:0];
		w.width    = width;
		word_q.insert(word_q.size(), w);
		repeat (steps) push_step();
	endtask

	function automatic int steps_to_end(int xb, int yb, int xf, int yf);
		int dx, dy;
		dx = (xf > xb) ? xf - xb : xb - xf;
		dy = (yf > yb) ? yf - yb : yb - yf;
		return ((dx > dy) ? dx : dy) + 1;
	endfunction

	function automatic int pick_coord();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return -2048;
		if (r == 1)
			return 2047;
		return int'($urandom_range(0, 4095)) - 2048;
	endfunction

	function automatic int near_coord(int c);
		int v;
		v = c + int'($urandom_range(0, 10)) - 5;
		if (v < -2048)
			v = -2048;
		if (v > 2047)
			v = 2047;
		return v;
	endfunction

	// Half are whole short lines; some are cut off by the next load, some run
	// past the end, far lines walk at most six points, some are a lone step.
	task automatic push_random_sequence(inout int count);
		int xb, yb, xf, yf, full, steps, kind;
		kind = $urandom_range(0, 19);
		if (kind == 0) begin
			push_step();
			count++;
			return;
		end
		xb = pick_coord();
		yb = pick_coord();
		if (kind < 5) begin
			xf = pick_coord();
			yf = pick_coord();
		end else begin
			xf = near_coord(xb);
			yf = near_coord(yb);
		end
		full = steps_to_end(xb, yb, xf, yf);
		if (kind == 1)
			steps = 0;
		else if (kind < 5)
			steps = $urandom_range(1, 6);
		else if (kind < 8)
			steps = $urandom_range(0, full - 1);
		else if (kind < 10)
			steps = full + int'($urandom_range(1, 2));
		else
			steps = full;
		push_line(xb, yb, xf, yf, $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 7),
			steps);
		count += 1 + steps;
	endtask

	task automatic wait_for_drain();
		while (word_q.size() != 0 || pixel_expect_q.size() != 0)
			@(negedge clk);
	endtask

	initial begin : run_control
		int random_items, chunk_items, calm_items;
		arst_n              = 1'b0;
		seg_bus.valid       = 1'b0;
		seg_bus.mode        = TLR_MODE_LOAD;
		seg_bus.x_begin     = '0;
		seg_bus.y_begin     = '0;
		seg_bus.x_finish    = '0;
		seg_bus.y_finish    = '0;
		seg_bus.red_in      = '0;
		seg_bus.green_in    = '0;
		seg_bus.blue_in     = '0;
		seg_bus.brush_width = '0;
		pix_bus.ready       = 1'b0;
		random_items        = 0;
		calm_items          = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// A step before any load, then lines at the corners of the range with
		// every brush half-width, a zero-length line, steps past the endpoint and
		// loads that cut a line short.
		push_step();
		push_line(-2048, -2048, -2046, -2047, 24'h000000, 3'd7, 3);
		push_line(2047, 2047, 2047, 2047, 24'hFFFFFF, 3'd1, 1);
		push_step();
		push_line(0, 0, 0, 2, 24'hFF00FF, 3'd0, 3);
		push_line(5, -5, -1, -9, 24'h00FF00, 3'd6, 2);
		push_line(-2048, 2047, 2047, -2048, 24'h0000FF, 3'd2, 3);
		push_line(100, 50, 98, 50, 24'hA55AC3, 3'd4, 3);
		push_line(-7, 12, -6, 14, 24'h3C7E01, 3'd3, 3);
		wait_for_drain();

		// Random chunks, each with its own mix of idling, each drained before
		// the next one starts.
		while (random_items < RANDOM_ITEMS) begin
			idle_send   = $urandom_range(0, 1);
			idle_recv   = $urandom_range(0, 3) != 0;
			chunk_items = 0;
			while (chunk_items < CHUNK_ITEMS)
				push_random_sequence(chunk_items);
			random_items += chunk_items;
			wait_for_drain();
		end

		idle_send = 1'b0;
		idle_recv = 1'b0;
		while (calm_items < CALM_ITEMS)
			push_random_sequence(calm_items);
		wait_for_drain();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Covered %0d line loads, %0d step words on a line and %0d while idle.",
			loads_taken, steps_taken, idle_steps_taken);
		$display("Compared %0d pixel words in %0d cycles, %0d mismatches.",
			pixels_checked, cycle_count, mismatch_count);
		if (mismatch_count == 0 && pixel_expect_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== thick_line_rasterizer_unit.f =====
hw/rtl/tlr_pkg.sv
hw/rtl/tlr_seg_if.sv
hw/rtl/tlr_pix_if.sv
hw/rtl/tlr_ctrl.sv
hw/rtl/tlr_datapath.sv
hw/rtl/thick_line_rasterizer_unit.sv
tb/testbench.sv
